// ===== hw/rtl/uwvc_pkg.sv =====
// uwvc_pkg: shared types, constants and character functions for the utf-8 word/vowel counter
// used by uwvc_front, uwvc_tok_fifo, uwvc_back and utf8_word_vowel_counter_unit
// no dependencies
package uwvc_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int OUT_W           = 32;
  localparam int VOWEL_CNT       = 6;

  localparam logic [7:0] CH_NONWORD = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_C   = 8'h63;
  localparam logic [7:0] CH_LOW_E   = 8'h65;
  localparam logic [7:0] CH_LOW_I   = 8'h69;
  localparam logic [7:0] CH_LOW_O   = 8'h6F;
  localparam logic [7:0] CH_LOW_U   = 8'h75;
  localparam logic [7:0] CH_LOW_Y   = 8'h79;
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] CASE_MASK  = 8'hDF;
  localparam logic [7:0] LEAD_LATIN = 8'hC3;
  localparam logic [7:0] LEAD_PUNCT = 8'hC2;
  localparam logic [7:0] GUIL_LEFT  = 8'hAB;
  localparam logic [7:0] GUIL_RIGHT = 8'hBB;
  localparam logic [7:0] QUOTE_LO   = 8'h98;
  localparam logic [7:0] QUOTE_HI   = 8'h99;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_LEAD  = 2'd1,
    ERR_TRUNC = 2'd2
  } err_t;

  // one decoded byte as seen by the counting side
  typedef struct packed {
    logic                 take;   // a character completed on this byte
    logic                 alnum;
    logic                 apos;
    logic [VOWEL_CNT-1:0] vowel;  // bit 0 a .. bit 5 y
    err_t                 err;
    logic                 eos;
  } token_t;

  typedef struct packed {
    logic                 alnum;
    logic                 apos;
    logic [VOWEL_CNT-1:0] vowel;
  } char_class_t;

  // continuation bytes still expected after a lead byte
  function automatic logic [1:0] seq_rest(input logic [7:0] lead);
    logic [1:0] r;
    if (lead[7:5] == 3'b110) begin
      r = 2'd1;
    end else if (lead[7:4] == 4'b1110) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic logic is_lead(input logic [7:0] b);
    return (b[7:5] == 3'b110) || (b[7:4] == 4'b1110) || (b[7:3] == 5'b11110);
  endfunction

  // fold a two-byte character to ascii, nonword when unknown
  function automatic logic [7:0] fold_two(input logic [7:0] lead, input logic [7:0] sec);
    logic [7:0] s;
    logic [7:0] r;
    s = sec & CASE_MASK;
    r = CH_NONWORD;
    if (lead == LEAD_LATIN) begin
      if (s inside {[8'h80:8'h83]}) begin
        r = CH_LOW_A;
      end else if (s inside {[8'h88:8'h8A]}) begin
        r = CH_LOW_E;
      end else if (s inside {8'h8C, 8'h8D}) begin
        r = CH_LOW_I;
      end else if (s inside {[8'h92:8'h95]}) begin
        r = CH_LOW_O;
      end else if (s inside {8'h99, 8'h9A}) begin
        r = CH_LOW_U;
      end else if (s == 8'h87) begin
        r = CH_LOW_C;
      end
    end else if (lead == LEAD_PUNCT && (sec inside {GUIL_LEFT, GUIL_RIGHT})) begin
      r = CH_SPACE;
    end
    return r;
  endfunction

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t c;
    c.alnum    = (ch inside {[8'h30:8'h39], [8'h61:8'h7A]});
    c.apos     = (ch == CH_APOS);
    c.vowel[0] = (ch == CH_LOW_A);
    c.vowel[1] = (ch == CH_LOW_E);
    c.vowel[2] = (ch == CH_LOW_I);
    c.vowel[3] = (ch == CH_LOW_O);
    c.vowel[4] = (ch == CH_LOW_U);
    c.vowel[5] = (ch == CH_LOW_Y);
    return c;
  endfunction

endpackage

// ===== hw/rtl/uwvc_front.sv =====
// uwvc_front: utf-8 byte decoder, groups bytes into characters and classifies them
// depends on uwvc_pkg
module uwvc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,       // byte accepted this cycle
  input  logic [7:0]        data_byte,
  input  logic              eos,
  output uwvc_pkg::token_t  tok
);

  logic [1:0]     pending_r, pending_nxt;
  logic [7:0]     lead_r, lead_nxt;
  logic           tq_r, tq_nxt;
  uwvc_pkg::err_t err_r, err_nxt;

  logic [7:0]            ch;
  logic                  take;
  logic [1:0]            rest;
  uwvc_pkg::char_class_t cls;

  always_comb begin
    pending_nxt = pending_r;
    lead_nxt    = lead_r;
    tq_nxt      = tq_r;
    err_nxt     = err_r;
    take        = 1'b0;
    ch          = uwvc_pkg::CH_NONWORD;
    rest        = uwvc_pkg::seq_rest(lead_r);
    if (acc && err_r == uwvc_pkg::ERR_NONE) begin
      if (pending_r == 2'd0) begin
        if (!data_byte[7]) begin
          take = 1'b1;
          ch   = (data_byte inside {[8'h41:8'h5A]}) ? (data_byte | uwvc_pkg::CASE_BIT)
                                                    : data_byte;
        end else if (uwvc_pkg::is_lead(data_byte)) begin
          lead_nxt    = data_byte;
          pending_nxt = uwvc_pkg::seq_rest(data_byte);
          tq_nxt      = 1'b0;
        end else begin
          err_nxt = uwvc_pkg::ERR_LEAD;
        end
      end else begin
        // a two-byte character completes on its second byte, so it is folded directly
        if (pending_r == rest - 2'd1) begin
          tq_nxt = (data_byte == uwvc_pkg::QUOTE_LO) || (data_byte == uwvc_pkg::QUOTE_HI);
        end
        pending_nxt = pending_r - 2'd1;
        if (pending_r == 2'd1) begin
          take = 1'b1;
          if (rest == 2'd1) begin
            ch = uwvc_pkg::fold_two(lead_r, data_byte);
          end else begin
            ch = tq_nxt ? uwvc_pkg::CH_APOS : uwvc_pkg::CH_NONWORD;
          end
        end
      end
      if (eos && err_nxt == uwvc_pkg::ERR_NONE && pending_nxt != 2'd0) begin
        err_nxt = uwvc_pkg::ERR_TRUNC;
      end
    end
  end

  always_comb begin
    cls       = uwvc_pkg::classify(ch);
    tok.take  = take;
    tok.alnum = cls.alnum;
    tok.apos  = cls.apos;
    tok.vowel = cls.vowel;
    tok.err   = err_nxt;
    tok.eos   = eos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && eos)) begin
      pending_r <= 2'd0;
      lead_r    <= 8'h00;
      tq_r      <= 1'b0;
      err_r     <= uwvc_pkg::ERR_NONE;
    end else if (acc) begin
      pending_r <= pending_nxt;
      lead_r    <= lead_nxt;
      tq_r      <= tq_nxt;
      err_r     <= err_nxt;
    end
  end

  // an erroneous byte never completes a character
  a_err_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    acc && tok.err != uwvc_pkg::ERR_NONE |-> !tok.take)
    else $error("character taken on an erroneous byte");

  // end of text puts the decoder back to its start state
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && eos |=> pending_r == 2'd0 && err_r == uwvc_pkg::ERR_NONE)
    else $error("decoder not cleared after end of text");

endmodule

// ===== hw/rtl/uwvc_tok_fifo.sv =====
// uwvc_tok_fifo: two-entry queue of decoded tokens between decoder and counters
// depends on uwvc_pkg
module uwvc_tok_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  uwvc_pkg::token_t wdata,
  output logic             full,
  input  logic             pop,
  output uwvc_pkg::token_t rdata,
  output logic             empty
);

  uwvc_pkg::token_t mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // fill level agrees with pointer distance
  a_fill_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2 && ((wr_ptr_r ^ rd_ptr_r) == cnt_r[0]))
    else $error("token queue fill level out of step with pointers");

endmodule

// ===== hw/rtl/uwvc_back.sv =====
// uwvc_back: word tracking, saturating word and vowel counters and the result register
// depends on uwvc_pkg
module uwvc_back #(
  parameter int COUNT_WIDTH = uwvc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  uwvc_pkg::token_t          tok,
  input  logic                      tok_valid,
  output logic                      tok_pop,
  output logic                      res_valid,
  input  logic                      res_pop,
  output logic [uwvc_pkg::OUT_W-1:0] res_cnt [uwvc_pkg::VOWEL_CNT+1],
  output uwvc_pkg::err_t            res_err,
  output logic                      res_eos
);

  localparam int NC = uwvc_pkg::VOWEL_CNT + 1;  // word counter first, then vowels
  localparam int OW = uwvc_pkg::OUT_W;

  logic [COUNT_WIDTH-1:0]         cnt_r   [NC];
  logic [COUNT_WIDTH-1:0]         cnt_upd [NC];
  logic [OW-1:0]                  clip    [NC];
  logic [OW-1:0]                  res_r   [NC];
  logic [uwvc_pkg::VOWEL_CNT-1:0] flags_r, flags_upd, base;
  logic                           in_word_r, in_word_upd, wordch;
  logic                           valid_r;
  uwvc_pkg::err_t                 err_r;
  logic                           eos_r;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  assign tok_pop = tok_valid && (!valid_r || res_pop);

  always_comb begin
    cnt_upd     = cnt_r;
    flags_upd   = flags_r;
    in_word_upd = in_word_r;
    base        = flags_r;
    wordch      = tok.alnum || (tok.apos && in_word_r);
    if (tok.take) begin
      if (!wordch) begin
        in_word_upd = 1'b0;
      end else begin
        if (!in_word_r) begin
          base        = '0;
          in_word_upd = 1'b1;
          cnt_upd[0]  = sat_inc(cnt_r[0]);
        end
        for (int k = 0; k < uwvc_pkg::VOWEL_CNT; k++) begin
          if (tok.vowel[k] && !base[k]) begin
            base[k]      = 1'b1;
            cnt_upd[k+1] = sat_inc(cnt_r[k+1]);
          end
        end
        flags_upd = base;
      end
    end
  end

  // clip each counter to the 32-bit result field
  for (genvar g = 0; g < NC; g++) begin : g_clip
    if (COUNT_WIDTH > OW) begin : g_wide
      assign clip[g] = (|cnt_upd[g][COUNT_WIDTH-1:OW]) ? {OW{1'b1}} : cnt_upd[g][OW-1:0];
    end else if (COUNT_WIDTH == OW) begin : g_same
      assign clip[g] = cnt_upd[g];
    end else begin : g_narrow
      assign clip[g] = {{(OW-COUNT_WIDTH){1'b0}}, cnt_upd[g]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (tok_pop && tok.eos)) begin
      for (int k = 0; k < NC; k++) begin
        cnt_r[k] <= '0;
      end
      flags_r   <= '0;
      in_word_r <= 1'b0;
    end else if (tok_pop) begin
      cnt_r     <= cnt_upd;
      flags_r   <= flags_upd;
      in_word_r <= in_word_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (tok_pop) begin
      valid_r <= 1'b1;
    end else if (res_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      res_r <= clip;
      err_r <= tok.err;
      eos_r <= tok.eos;
    end
  end

  assign res_valid = valid_r;
  assign res_cnt   = res_r;
  assign res_err   = err_r;
  assign res_eos   = eos_r;

  // no vowel count can pass the word count
  a_vowel_le_word: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> res_r[1] <= res_r[0] && res_r[2] <= res_r[0] && res_r[3] <= res_r[0] &&
                res_r[4] <= res_r[0] && res_r[5] <= res_r[0] && res_r[6] <= res_r[0])
    else $error("vowel word count above word count");

endmodule

// ===== hw/rtl/utf8_word_vowel_counter_unit.sv =====
// utf8_word_vowel_counter_unit: counts words and words holding a, e, i, o, u, y in utf-8 text
// path: a byte's token is stored in the token queue, then its totals in the result register
// a new byte is taken while earlier results wait, until the token queue is full
// reset: rst_n low clears decoder, token queue, counters and result valid
// depends on uwvc_pkg, uwvc_front, uwvc_tok_fifo, uwvc_back
module utf8_word_vowel_counter_unit #(
  parameter int COUNT_WIDTH = uwvc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input queue side: one text byte per push
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  input  logic        in_push,
  output logic        in_full,
  // result queue side: running totals after each byte
  output logic [31:0] out_word_total,
  output logic [31:0] out_words_with_a,
  output logic [31:0] out_words_with_e,
  output logic [31:0] out_words_with_i,
  output logic [31:0] out_words_with_o,
  output logic [31:0] out_words_with_u,
  output logic [31:0] out_words_with_y,
  output logic [1:0]  out_error_code,
  output logic        out_stream_done,
  output logic        out_empty,
  input  logic        out_pop
);

  // front end: decodes utf-8 and hands one token per byte to the queue
  // back end: keeps per-word vowel flags and the saturating counters
  uwvc_pkg::token_t         tok_in, tok_out;
  logic                     in_acc;
  logic                     q_empty, q_pop;
  logic                     res_valid;
  logic [uwvc_pkg::OUT_W-1:0] res_cnt [uwvc_pkg::VOWEL_CNT+1];
  uwvc_pkg::err_t           res_err;

  // the queue being full is the only input stall
  assign in_acc = in_push && !in_full;

  uwvc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .data_byte (in_data_byte),
    .eos       (in_end_of_stream),
    .tok       (tok_in)
  );

  // two entries so the decoder keeps going while a result waits
  uwvc_tok_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_acc),
    .wdata (tok_in),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (tok_out),
    .empty (q_empty)
  );

  // result register acts as the output stage; it reloads in the cycle it is popped when a token waits
  uwvc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (tok_out),
    .tok_valid (!q_empty),
    .tok_pop   (q_pop),
    .res_valid (res_valid),
    .res_pop   (out_pop),
    .res_cnt   (res_cnt),
    .res_err   (res_err),
    .res_eos   (out_stream_done)
  );

  assign out_empty        = !res_valid;
  assign out_word_total   = res_cnt[0];
  assign out_words_with_a = res_cnt[1];
  assign out_words_with_e = res_cnt[2];
  assign out_words_with_i = res_cnt[3];
  assign out_words_with_o = res_cnt[4];
  assign out_words_with_u = res_cnt[5];
  assign out_words_with_y = res_cnt[6];
  assign out_error_code   = res_err;

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for utf8_word_vowel_counter_unit
// drives utf-8 byte streams through the push/full side, checks every result against a
// behavioral tally of words and vowel-words or a hand-written expectation; depends on uwvc_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;

  // running totals as they appear on the result side
  typedef struct packed {
    logic [31:0]      words;
    logic [5:0][31:0] vw;     // 0 a, 1 e, 2 i, 3 o, 4 u, 5 y
    uwvc_pkg::err_t   err;
    logic             done;
  } tally_t;

  // one row of the hand-written stream; want is used only when typed is set
  typedef struct {
    logic [7:0] b;
    logic       eos;
    logic       typed;
    tally_t     want;
  } dir_row_t;

  localparam int TARGET_BYTES = 1150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_stream = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [31:0] out_word_total;
  logic [31:0] out_words_with_a;
  logic [31:0] out_words_with_e;
  logic [31:0] out_words_with_i;
  logic [31:0] out_words_with_o;
  logic [31:0] out_words_with_u;
  logic [31:0] out_words_with_y;
  logic [1:0]  out_error_code;
  logic        out_stream_done;
  logic        out_empty;
  logic        out_pop = 1'b0;

  // shadow of the decoder and counters
  logic [1:0]       pend;
  logic [7:0]       lead_q;
  logic [7:0]       sec_q;
  logic             quote3;
  logic             in_word;
  logic [5:0]       seen;
  logic [31:0]      n_words;
  logic [5:0][31:0] n_vowel;
  uwvc_pkg::err_t   err_st;

  tally_t   totals_q[$];     // expected totals, oldest first
  dir_row_t dir_rows[$];
  logic [7:0] text_buf[$];   // one random stream being assembled
  int       mismatch_cnt = 0;
  int       sent_bytes = 0;  // every byte accepted so far
  int       burst_left = 0;
  int       rx_cyc = 0;

  utf8_word_vowel_counter_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .in_push          (in_push),
    .in_full          (in_full),
    .out_word_total   (out_word_total),
    .out_words_with_a (out_words_with_a),
    .out_words_with_e (out_words_with_e),
    .out_words_with_i (out_words_with_i),
    .out_words_with_o (out_words_with_o),
    .out_words_with_u (out_words_with_u),
    .out_words_with_y (out_words_with_y),
    .out_error_code   (out_error_code),
    .out_stream_done  (out_stream_done),
    .out_empty        (out_empty),
    .out_pop          (out_pop)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // behavioral tally
  // ---------------------------------------------------------------------------

  function automatic void clear_text();
    pend    = 2'd0;
    lead_q  = 8'h00;
    sec_q   = 8'h00;
    quote3  = 1'b0;
    in_word = 1'b0;
    seen    = '0;
    n_words = '0;
    n_vowel = '0;
    err_st  = uwvc_pkg::ERR_NONE;
  endfunction

  // accented latin letters fold to their base vowel (or c), guillemets to a space
  function automatic logic [7:0] fold_pair(input logic [7:0] lead, input logic [7:0] sec);
    logic [7:0] s;
    logic [7:0] r;
    s = sec & uwvc_pkg::CASE_MASK;
    r = uwvc_pkg::CH_NONWORD;
    if (lead == uwvc_pkg::LEAD_LATIN) begin
      case (s)
        8'h80, 8'h81, 8'h82, 8'h83: r = uwvc_pkg::CH_LOW_A;
        8'h88, 8'h89, 8'h8A:        r = uwvc_pkg::CH_LOW_E;
        8'h8C, 8'h8D:               r = uwvc_pkg::CH_LOW_I;
        8'h92, 8'h93, 8'h94, 8'h95: r = uwvc_pkg::CH_LOW_O;
        8'h99, 8'h9A:               r = uwvc_pkg::CH_LOW_U;
        8'h87:                      r = uwvc_pkg::CH_LOW_C;
        default:                    r = uwvc_pkg::CH_NONWORD;
      endcase
    end else if (lead == uwvc_pkg::LEAD_PUNCT &&
                 (sec == uwvc_pkg::GUIL_LEFT || sec == uwvc_pkg::GUIL_RIGHT)) begin
      r = uwvc_pkg::CH_SPACE;
    end
    return r;
  endfunction

  // one completed, lower-cased character enters the word tracker
  function automatic void absorb_char(input logic [7:0] ch);
    logic alnum;
    logic wordch;
    int   vk;
    alnum  = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h7A);
    wordch = alnum || (ch == uwvc_pkg::CH_APOS && in_word);
    if (!wordch) begin
      in_word = 1'b0;
      return;
    end
    if (!in_word) begin
      in_word = 1'b1;
      seen    = '0;
      if (n_words != '1) n_words = n_words + 32'd1;
    end
    case (ch)
      uwvc_pkg::CH_LOW_A: vk = 0;
      uwvc_pkg::CH_LOW_E: vk = 1;
      uwvc_pkg::CH_LOW_I: vk = 2;
      uwvc_pkg::CH_LOW_O: vk = 3;
      uwvc_pkg::CH_LOW_U: vk = 4;
      uwvc_pkg::CH_LOW_Y: vk = 5;
      default:            vk = -1;
    endcase
    // sticky flag: a word counts once per vowel
    if (vk >= 0 && !seen[vk]) begin
      seen[vk] = 1'b1;
      if (n_vowel[vk] != '1) n_vowel[vk] = n_vowel[vk] + 32'd1;
    end
  endfunction

  // advance the tally by one byte and return the totals the block should show
  function automatic tally_t text_step(input logic [7:0] b, input logic eos);
    tally_t r;
    int     len;
    int     pos;
    if (err_st == uwvc_pkg::ERR_NONE) begin
      if (pend == 2'd0) begin
        if (!b[7]) begin
          absorb_char((b >= 8'h41 && b <= 8'h5A) ? (b | uwvc_pkg::CASE_BIT) : b);
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
          lead_q = b;
          pend   = (b[7:5] == 3'b110) ? 2'd1 : (b[7:4] == 4'b1110) ? 2'd2 : 2'd3;
          sec_q  = 8'h00;
          quote3 = 1'b0;
        end else begin
          err_st = uwvc_pkg::ERR_LEAD;
        end
      end else begin
        len = (lead_q[7:5] == 3'b110) ? 2 : (lead_q[7:4] == 4'b1110) ? 3 : 4;
        pos = len - int'(pend);
        if (pos == 1) sec_q = b;
        if (pos == 2) quote3 = (b == uwvc_pkg::QUOTE_LO || b == uwvc_pkg::QUOTE_HI);
        pend = pend - 2'd1;
        if (pend == 2'd0) begin
          if (len == 2) begin
            absorb_char(fold_pair(lead_q, sec_q));
          end else begin
            absorb_char(quote3 ? uwvc_pkg::CH_APOS : uwvc_pkg::CH_NONWORD);
          end
        end
      end
      // marker inside an unfinished character
      if (eos && err_st == uwvc_pkg::ERR_NONE && pend != 2'd0) err_st = uwvc_pkg::ERR_TRUNC;
    end
    r.words = n_words;
    r.vw    = n_vowel;
    r.err   = err_st;
    r.done  = eos;
    if (eos) clear_text();
    return r;
  endfunction

  function automatic tally_t mk_tally(input logic [31:0] w, input logic [31:0] na,
                                      input uwvc_pkg::err_t e, input logic d);
    tally_t t;
    t       = '0;
    t.words = w;
    t.vw[0] = na;
    t.err   = e;
    t.done  = d;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // present one byte, wait for the push to be taken, then record its totals
  task automatic push_byte(input logic [7:0] b, input logic eos, input logic typed,
                           input tally_t want);
    tally_t t;
    if (burst_left == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // mostly short bursts, now and then a long unbroken run
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_data_byte     <= b;
    in_end_of_stream <= eos;
    in_push          <= 1'b1;
    do @(posedge clk); while (in_full !== 1'b0);
    sent_bytes++;
    t = text_step(b, eos);
    totals_q.push_back(typed ? want : t);
    burst_left--;
  endtask

  task automatic add_row(input logic [7:0] b, input logic eos, input logic typed,
                         input tally_t want);
    dir_row_t r;
    r.b     = b;
    r.eos   = eos;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  // continuation bytes are not checked by the block, so stray values go in too
  function automatic logic [7:0] cont_byte();
    logic [7:0] c;
    if ($urandom_range(0, 4) == 0) begin
      c = 8'($urandom_range(0, 255));
    end else begin
      c = 8'($urandom_range(8'h80, 8'hBF));
    end
    return c;
  endfunction

  // append one character of random text, weighted toward letters and vowels
  task automatic add_char();
    string      vowel_set;
    int         sel;
    logic [7:0] c;
    vowel_set = "aeiouyAEIOUY";
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      if ($urandom_range(0, 1) == 1) begin
        c = vowel_set[$urandom_range(0, 11)];
      end else begin
        c = 8'($urandom_range(0, 25)) + (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61);
      end
      text_buf.push_back(c);
    end else if (sel < 48) begin
      text_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
    end else if (sel < 58) begin
      c = 8'($urandom_range(0, 127));
      text_buf.push_back(c);
    end else if (sel < 62) begin
      text_buf.push_back(uwvc_pkg::CH_APOS);
    end else if (sel < 74) begin
      text_buf.push_back(uwvc_pkg::LEAD_LATIN);
      c = 8'($urandom_range(8'h80, 8'hBF));
      text_buf.push_back(c);
    end else if (sel < 78) begin
      text_buf.push_back(uwvc_pkg::LEAD_PUNCT);
      if ($urandom_range(0, 1) == 1) begin
        text_buf.push_back(($urandom_range(0, 1) == 1) ? uwvc_pkg::GUIL_LEFT
                                                       : uwvc_pkg::GUIL_RIGHT);
      end else begin
        text_buf.push_back(cont_byte());
      end
    end else if (sel < 90) begin
      // three- and four-byte characters, quote marks ride on the third byte
      if (sel < 85) begin
        c = 8'($urandom_range(8'hE0, 8'hEF));
      end else begin
        c = 8'($urandom_range(8'hF0, 8'hF7));
      end
      text_buf.push_back(c);
      text_buf.push_back(cont_byte());
      if ($urandom_range(0, 1) == 1) begin
        text_buf.push_back(($urandom_range(0, 1) == 1) ? uwvc_pkg::QUOTE_LO
                                                       : uwvc_pkg::QUOTE_HI);
      end else begin
        text_buf.push_back(cont_byte());
      end
      if (sel >= 85) text_buf.push_back(cont_byte());
    end else if (sel < 95) begin
      // raw noise, may hit an invalid lead
      c = 8'($urandom_range(0, 255));
      text_buf.push_back(c);
    end else begin
      c = 8'($urandom_range(8'hC0, 8'hDF));
      text_buf.push_back(c);
      text_buf.push_back(cont_byte());
    end
  endtask

  // one complete text with the end marker on its last byte
  task automatic send_stream();
    int         nch;
    int         rest;
    logic [7:0] lead;
    text_buf.delete();
    nch = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    repeat (nch) add_char();
    // now and then cut the last character short
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0:       lead = 8'($urandom_range(8'hC0, 8'hDF));
        1:       lead = 8'($urandom_range(8'hE0, 8'hEF));
        default: lead = 8'($urandom_range(8'hF0, 8'hF7));
      endcase
      rest = (lead[7:5] == 3'b110) ? 1 : (lead[7:4] == 4'b1110) ? 2 : 3;
      text_buf.push_back(lead);
      repeat ($urandom_range(0, rest - 1)) text_buf.push_back(cont_byte());
    end
    foreach (text_buf[i]) begin
      push_byte(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // pop on a pattern that rotates among free flow, coin flip,
  // one pop in eight, and four pops in five
  always @(posedge clk) begin
    tally_t want;
    string  letters;
    letters = "aeiouy";
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (totals_q.size() == 0) begin
          $error("result word with no expected totals waiting");
          mismatch_cnt++;
        end else begin
          want = totals_q.pop_front();
          cmp_field("word_total", want.words, out_word_total);
          cmp_field($sformatf("words_with_%c", letters[0]), want.vw[0], out_words_with_a);
          cmp_field($sformatf("words_with_%c", letters[1]), want.vw[1], out_words_with_e);
          cmp_field($sformatf("words_with_%c", letters[2]), want.vw[2], out_words_with_i);
          cmp_field($sformatf("words_with_%c", letters[3]), want.vw[3], out_words_with_o);
          cmp_field($sformatf("words_with_%c", letters[4]), want.vw[4], out_words_with_u);
          cmp_field($sformatf("words_with_%c", letters[5]), want.vw[5], out_words_with_y);
          cmp_field("error_code", 32'(want.err), 32'(out_error_code));
          cmp_field("stream_done", 32'(want.done), 32'(out_stream_done));
        end
      end
      case ((rx_cyc / 256) % 4)
        0:       out_pop <= 1'b1;
        1:       out_pop <= 1'($urandom_range(0, 1));
        2:       out_pop <= (rx_cyc % 8 == 0);
        default: out_pop <= (rx_cyc % 5 != 0);
      endcase
      rx_cyc++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    clear_text();
    // invalid lead first thing after reset: counts stay at zero and freeze
    add_row(8'h80, 1'b0, 1'b1, mk_tally(32'd0, 32'd0, uwvc_pkg::ERR_LEAD, 1'b0));
    add_row(8'h41, 1'b1, 1'b1, mk_tally(32'd0, 32'd0, uwvc_pkg::ERR_LEAD, 1'b1));
    // upper-case letter opens a word after the clear
    add_row(8'h41, 1'b0, 1'b1, mk_tally(32'd1, 32'd1, uwvc_pkg::ERR_NONE, 1'b0));
    // right single quote keeps the word going
    add_row(8'hE2, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h99, 1'b0, 1'b0, '0);
    add_row(8'h59, 1'b0, 1'b0, '0);
    // guillemet acts as a space
    add_row(8'hC2, 1'b0, 1'b0, '0);
    add_row(8'hAB, 1'b0, 1'b0, '0);
    // accented capital e folds to e
    add_row(8'hC3, 1'b0, 1'b0, '0);
    add_row(8'h89, 1'b0, 1'b0, '0);
    // unknown two-byte character ends the word
    add_row(8'hC3, 1'b0, 1'b0, '0);
    add_row(8'hBF, 1'b0, 1'b0, '0);
    // apostrophe outside a word is not a word character
    add_row(uwvc_pkg::CH_APOS, 1'b0, 1'b0, '0);
    add_row(8'h39, 1'b0, 1'b0, '0);
    // four-byte character with a quote third byte continues the digit word
    add_row(8'hF0, 1'b0, 1'b0, '0);
    add_row(8'h9F, 1'b0, 1'b0, '0);
    add_row(uwvc_pkg::QUOTE_LO, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h7A, 1'b0, 1'b0, '0);
    // top lead byte is invalid, end marker still closes the text
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, '0);
    // marker right on a lead byte: truncated character
    add_row(uwvc_pkg::LEAD_LATIN, 1'b1, 1'b1,
            mk_tally(32'd0, 32'd0, uwvc_pkg::ERR_TRUNC, 1'b1));
    // first invalid value above the four-byte leads
    add_row(8'hF8, 1'b1, 1'b1, mk_tally(32'd0, 32'd0, uwvc_pkg::ERR_LEAD, 1'b1));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      push_byte(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].typed, dir_rows[i].want);
    end
    while (sent_bytes < TARGET_BYTES) send_stream();
    in_push <= 1'b0;

    // drain, then wait on for any stray result word
    while (totals_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
